### hw/rtl/ife_pkg.sv
package ife_pkg;

   localparam int MAX_WIDTH    = 128;
   localparam int MAX_HEIGHT   = 128;
   localparam int MAX_CHANNELS = 4;

   // counter widths; the store uses power-of-two pitches per axis
   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CHN_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ADDR_W = ROW_W + COL_W + CHN_W;

   // widths able to hold the clamped sizes themselves
   localparam int WL_W = $clog2(MAX_WIDTH + 1);
   localparam int HL_W = $clog2(MAX_HEIGHT + 1);
   localparam int NL_W = $clog2(MAX_CHANNELS + 1);

   localparam int SAMPLE_W  = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      FLIP_VERT = 2'd0,
      FLIP_HORZ = 2'd1,
      FLIP_BOTH = 2'd2
   } flip_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_CHANNELS     = 2'd2,
      CSR_FLIP_MODE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                op;
      logic [SAMPLE_W-1:0] sample_in;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
      logic                last;
      logic                not_ready;
   } rsp_type;

   typedef struct packed {
      logic [7:0] frame_width;
      logic [7:0] frame_height;
      logic [2:0] channels;
      logic [1:0] flip_mode;
   } cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [CHN_W-1:0] chan;
   } pos_type;

   typedef struct packed {
      pos_type pos;
      logic    wrap;
   } adv_type;

   // memory access issued by the sequencer
   typedef struct packed {
      logic                wr_en;
      logic                rd_en;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] wdata;
   } mem_req_type;

   // what travels alongside a read towards the output
   typedef struct packed {
      logic is_read;
      logic last;
      logic not_ready;
   } rd_info_type;

endpackage

### hw/rtl/ife_ram.sv
module ife_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ife_ctrl.sv
module ife_ctrl
   import ife_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  req_type              req,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output mem_req_type          mem_req,
   output rd_info_type          rd_info
);

   cfg_type cfg_ff, cfg_in;
   pos_type load_ff, load_in;
   pos_type read_ff, read_in;
   logic    full_ff, full_in;

   logic [WL_W-1:0] lim_w;
   logic [HL_W-1:0] lim_h;
   logic [NL_W-1:0] lim_n;
   logic            vflip, hflip;
   pos_type         ld_pos;
   adv_type         ld_adv, rd_adv;
   logic [HL_W-1:0] mir_row;
   logic [WL_W-1:0] mir_col;
   logic [ROW_W-1:0] src_row;
   logic [COL_W-1:0] src_col;

   function automatic adv_type advance(pos_type p, logic [WL_W-1:0] w,
                                       logic [HL_W-1:0] h, logic [NL_W-1:0] n);
      adv_type a;
      a.pos  = p;
      a.wrap = 1'b0;
      if ((CHN_W+1)'(p.chan) + 1'b1 < (CHN_W+1)'(n)) begin
         a.pos.chan = p.chan + 1'b1;
      end else begin
         a.pos.chan = '0;
         if ((COL_W+1)'(p.col) + 1'b1 < (COL_W+1)'(w)) begin
            a.pos.col = p.col + 1'b1;
         end else begin
            a.pos.col = '0;
            if ((ROW_W+1)'(p.row) + 1'b1 < (ROW_W+1)'(h)) begin
               a.pos.row = p.row + 1'b1;
            end else begin
               a.pos.row = '0;
               a.wrap    = 1'b1;
            end
         end
      end
      return a;
   endfunction

   // size registers: zero acts as one, oversize saturates
   always_comb begin
      if (cfg_ff.frame_width == '0) begin
         lim_w = WL_W'(1);
      end else if (32'(cfg_ff.frame_width) > MAX_WIDTH) begin
         lim_w = WL_W'(MAX_WIDTH);
      end else begin
         lim_w = WL_W'(cfg_ff.frame_width);
      end
      if (cfg_ff.frame_height == '0) begin
         lim_h = HL_W'(1);
      end else if (32'(cfg_ff.frame_height) > MAX_HEIGHT) begin
         lim_h = HL_W'(MAX_HEIGHT);
      end else begin
         lim_h = HL_W'(cfg_ff.frame_height);
      end
      if (cfg_ff.channels == '0) begin
         lim_n = NL_W'(1);
      end else if (32'(cfg_ff.channels) > MAX_CHANNELS) begin
         lim_n = NL_W'(MAX_CHANNELS);
      end else begin
         lim_n = NL_W'(cfg_ff.channels);
      end
   end

   assign vflip = (cfg_ff.flip_mode == FLIP_VERT) || (cfg_ff.flip_mode == FLIP_BOTH);
   assign hflip = (cfg_ff.flip_mode == FLIP_HORZ) || (cfg_ff.flip_mode == FLIP_BOTH);

   // a load after a full frame restarts at the origin
   assign ld_pos = full_ff ? pos_type'('0) : load_ff;
   assign ld_adv = advance(ld_pos, lim_w, lim_h, lim_n);
   assign rd_adv = advance(read_ff, lim_w, lim_h, lim_n);

   assign mir_row = lim_h - HL_W'(1) - HL_W'(read_ff.row);
   assign mir_col = lim_w - WL_W'(1) - WL_W'(read_ff.col);
   assign src_row = (vflip && (HL_W'(read_ff.row) < lim_h)) ? mir_row[ROW_W-1:0]
                                                             : read_ff.row;
   assign src_col = (hflip && (WL_W'(read_ff.col) < lim_w)) ? mir_col[COL_W-1:0]
                                                             : read_ff.col;

   always_comb begin
      cfg_in  = cfg_ff;
      load_in = load_ff;
      read_in = read_ff;
      full_in = full_ff;

      mem_req.wr_en = 1'b0;
      mem_req.rd_en = 1'b0;
      mem_req.addr  = {ld_pos.row, ld_pos.col, ld_pos.chan};
      mem_req.wdata = req.sample_in;

      rd_info.is_read   = 1'b0;
      rd_info.last      = 1'b0;
      rd_info.not_ready = 1'b0;

      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_wdata;
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_wdata;
            CSR_CHANNELS:     cfg_in.channels     = csr_wdata[2:0];
            CSR_FLIP_MODE:    cfg_in.flip_mode    = csr_wdata[1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end

      if (accept) begin
         if (req.op == OP_LOAD) begin
            mem_req.wr_en = 1'b1;
            load_in       = ld_adv.pos;
            if (ld_adv.wrap) begin
               full_in = 1'b1;
               read_in = '0;
            end else if (full_ff) begin
               full_in = 1'b0;
               read_in = '0;
            end
         end else begin
            rd_info.is_read = 1'b1;
            if (!full_ff) begin
               rd_info.not_ready = 1'b1;
            end else begin
               mem_req.rd_en = 1'b1;
               mem_req.addr  = {src_row, src_col, read_ff.chan};
               rd_info.last  = rd_adv.wrap;
               read_in       = rd_adv.pos;
               if (rd_adv.wrap) begin
                  full_in = 1'b0;
                  load_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= 8'd128;
         cfg_ff.frame_height <= 8'd128;
         cfg_ff.channels     <= 3'd3;
         cfg_ff.flip_mode    <= FLIP_VERT;
         load_ff             <= '0;
         read_ff             <= '0;
         full_ff             <= 1'b0;
      end else begin
         cfg_ff  <= cfg_in;
         load_ff <= load_in;
         read_ff <= read_in;
         full_ff <= full_in;
      end
   end

endmodule

### hw/rtl/image_flip_engine_unit.sv
// Frame flipper for interleaved 8-bit images. Load requests (op 0) write
// samples in raster order into a 64K x 8 frame store; once a whole frame is
// in, read requests (op 1) return it mirrored by flip_mode, one sample each,
// with last on the final one, after which the frame is free again. A read
// before the frame is complete answers 0 with not_ready set. One request is
// taken per clock while not stalled; a read's data is captured in the store
// read stage at the edge that takes the request and moves into the output
// register, which drives rsp, once that register is free. Requests stall only
// while the output register and the store read stage both hold an unclaimed
// response. Size and mode registers are to be written through the csr port
// only while no request is in flight; the block itself does not enforce this.
module image_flip_engine_unit
   import ife_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   mem_req_type         mem_req;
   rd_info_type         rd_info;
   logic [SAMPLE_W-1:0] rd_data;
   logic                accept;
   logic                out_free;
   logic                move;

   logic        pend_ff, pend_in;
   rd_info_type pend_info_ff, pend_info_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   ife_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mem_req   (mem_req),
      .rd_info   (rd_info)
   );

   ife_ram #(
      .DATA_W (SAMPLE_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .rd_en   (mem_req.rd_en),
      .addr    (mem_req.addr),
      .wr_data (mem_req.wdata),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign move      = pend_ff && out_free;
   assign req_ready = !pend_ff || out_free;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      pend_in      = pend_ff && !move;
      pend_info_in = pend_info_ff;
      if (accept && rd_info.is_read) begin
         pend_in      = 1'b1;
         pend_info_in = rd_info;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (move) begin
         rsp_valid_in      = 1'b1;
         rsp_in.sample_out = pend_info_ff.not_ready ? '0 : rd_data;
         rsp_in.last       = pend_info_ff.last;
         rsp_in.not_ready  = pend_info_ff.not_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_info_ff <= pend_info_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/ife_checker.sv
module ife_checker
   import ife_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // response held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response visible straight after reset");

   // an early read cannot also end a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.last && rsp_data.not_ready))
      else $error("last and not_ready both set");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.not_ready |-> rsp_data.sample_out == '0)
      else $error("not_ready response carries a sample");

   // input only backs up behind a held response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("request stalled with no response waiting");

endmodule

bind image_flip_engine_unit ife_checker u_ife_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### bench/image_flip_engine_unit_test.sv
`timescale 1ns / 100ps

module image_flip_engine_unit_test;
   import ife_pkg::*;

   localparam int STORE_SIZE = 1 << ADDR_W;

   // Mirror of the frame store, positions and registers; predicts each read response.
   class flip_scoreboard;
      logic [7:0]          width_reg;
      logic [7:0]          height_reg;
      logic [2:0]          chan_reg;
      logic [1:0]          mode_reg;
      logic [SAMPLE_W-1:0] frame_copy [STORE_SIZE];
      bit                  written [STORE_SIZE];
      logic [ROW_W-1:0]    load_row, read_row;
      logic [COL_W-1:0]    load_col, read_col;
      logic [CHN_W-1:0]    load_chan, read_chan;
      bit                  full;
      rsp_type             expected_samples [$];
      int                  errors;

      function new();
         width_reg  = 8'd128;
         height_reg = 8'd128;
         chan_reg   = 3'd3;
         mode_reg   = FLIP_VERT;
         load_row   = '0;
         load_col   = '0;
         load_chan  = '0;
         read_row   = '0;
         read_col   = '0;
         read_chan  = '0;
         full       = 1'b0;
         errors     = 0;
      endfunction

      function int unsigned clamp_to(int unsigned v, int unsigned top);
         if (v == 0) return 1;
         return (v > top) ? top : v;
      endfunction

      function void write_reg(csr_index_type idx, logic [7:0] v);
         case (idx)
            CSR_FRAME_WIDTH:  width_reg  = v;
            CSR_FRAME_HEIGHT: height_reg = v;
            CSR_CHANNELS:     chan_reg   = v[2:0];
            CSR_FLIP_MODE:    mode_reg   = v[1:0];
            default: ;
         endcase
      endfunction

      function int unsigned store_index(int unsigned r, int unsigned c, int unsigned ch);
         return (r * MAX_WIDTH + c) * MAX_CHANNELS + ch;
      endfunction

      // raster step; returns 1 when the frame wraps
      function bit advance(inout logic [ROW_W-1:0] r, inout logic [COL_W-1:0] c,
                           inout logic [CHN_W-1:0] ch);
         int unsigned w, h, n;
         w = clamp_to(width_reg, MAX_WIDTH);
         h = clamp_to(height_reg, MAX_HEIGHT);
         n = clamp_to(chan_reg, MAX_CHANNELS);
         if (ch + 1 < n) begin
            ch = ch + 1'b1;
            return 1'b0;
         end
         ch = '0;
         if (c + 1 < w) begin
            c = c + 1'b1;
            return 1'b0;
         end
         c = '0;
         if (r + 1 < h) begin
            r = r + 1'b1;
            return 1'b0;
         end
         r = '0;
         return 1'b1;
      endfunction

      // store entry the next read fetches; a position past the in-use size is not mirrored
      function int unsigned read_source();
         int unsigned w, h, sr, sc;
         w  = clamp_to(width_reg, MAX_WIDTH);
         h  = clamp_to(height_reg, MAX_HEIGHT);
         sr = read_row;
         sc = read_col;
         if ((mode_reg == FLIP_VERT || mode_reg == FLIP_BOTH) && read_row < h)
            sr = h - 1 - read_row;
         if ((mode_reg == FLIP_HORZ || mode_reg == FLIP_BOTH) && read_col < w)
            sc = w - 1 - read_col;
         return store_index(sr, sc, read_chan);
      endfunction

      function bit read_safe();
         return !full || written[read_source()];
      endfunction

      function int outstanding();
         return expected_samples.size();
      endfunction

      function void take_request(req_type r);
         rsp_type     e;
         int unsigned a;
         if (r.op == OP_LOAD) begin
            if (full) begin
               full      = 1'b0;
               read_row  = '0;
               read_col  = '0;
               read_chan = '0;
               load_row  = '0;
               load_col  = '0;
               load_chan = '0;
            end
            a             = store_index(load_row, load_col, load_chan);
            frame_copy[a] = r.sample_in;
            written[a]    = 1'b1;
            if (advance(load_row, load_col, load_chan)) begin
               full      = 1'b1;
               read_row  = '0;
               read_col  = '0;
               read_chan = '0;
            end
            return;
         end
         e = '0;
         if (!full) begin
            e.not_ready = 1'b1;
         end else begin
            e.sample_out = frame_copy[read_source()];
            e.last       = advance(read_row, read_col, read_chan);
            if (e.last) begin
               full      = 1'b0;
               load_row  = '0;
               load_col  = '0;
               load_chan = '0;
            end
         end
         expected_samples.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected response sample_out %0h last %0b not_ready %0b",
                     $time, got.sample_out, got.last, got.not_ready);
            errors++;
            return;
         end
         e = expected_samples.pop_front();
         if (got.sample_out !== e.sample_out) begin
            $display("%0t: sample_out expected %0h actual %0h", $time, e.sample_out,
                     got.sample_out);
            errors++;
         end
         if (got.last !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, got.last);
            errors++;
         end
         if (got.not_ready !== e.not_ready) begin
            $display("%0t: not_ready expected %0b actual %0b", $time, e.not_ready,
                     got.not_ready);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   flip_scoreboard sb;
   bit             rsp_idle_on;
   bit             hold_pending;

   image_flip_engine_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("[image_flip_engine_unit] ERROR");
      $finish;
   end

   // response side: short random stalls, plus one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending && rsp_valid) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (60) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_data);
   end

   task automatic send_request(op_type op, logic [SAMPLE_W-1:0] value);
      req_type r;
      r.op        = op;
      r.sample_in = value;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.take_request(r);
   endtask

   // wait for every response, then for any load still inside the pipe
   task automatic drain();
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [7:0] w, logic [7:0] h, logic [7:0] ch, logic [7:0] mode);
      logic [7:0] vals [4];
      vals[0] = w;
      vals[1] = h;
      vals[2] = ch;
      vals[3] = mode;
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(csr_index_type'(i), vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // mostly whole frames loaded then read back, with early reads and aborted frames mixed in
   task automatic run_phase(int n_items, bit idle_on, bit want_hold);
      op_type op;
      rsp_idle_on = idle_on;
      for (int i = 0; i < n_items; i++) begin
         if (sb.full)
            op = ($urandom_range(0, 199) == 0 || !sb.read_safe()) ? OP_LOAD : OP_READ;
         else
            op = ($urandom_range(0, 39) == 0) ? OP_READ : OP_LOAD;
         if (want_hold && op == OP_READ && sb.full) begin
            hold_pending = 1'b1;
            want_hold    = 1'b0;
         end
         send_request(op, SAMPLE_W'($urandom_range(0, 255)));
         if (idle_on && i < n_items - 1 && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'($urandom_range(128, 255));
         default: return 8'($urandom_range(1, 6));
      endcase
   endfunction

   initial begin
      int          random_done;
      int          frame, n_items;
      logic [7:0]  w, h, ch, mode;

      sb           = new();
      rsp_idle_on  = 1'b1;
      hold_pending = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes: early reads, and a partial frame left behind
      send_request(OP_READ, 8'h00);
      send_request(OP_READ, 8'hFF);
      send_request(OP_LOAD, 8'h00);
      send_request(OP_LOAD, 8'hFF);
      send_request(OP_READ, 8'h3C);
      req_valid <= 1'b0;
      drain();

      // shrink mid-frame, then a full frame, an abandoned read-back and a clean one
      configure(8'd2, 8'd2, 8'd1, FLIP_BOTH);
      send_request(OP_LOAD, 8'h11);
      send_request(OP_LOAD, 8'h22);
      send_request(OP_LOAD, 8'h33);
      send_request(OP_LOAD, 8'hFF);
      send_request(OP_READ, 8'h00);
      send_request(OP_READ, 8'h00);
      send_request(OP_LOAD, 8'h00);
      send_request(OP_LOAD, 8'h5A);
      send_request(OP_LOAD, 8'hA5);
      send_request(OP_LOAD, 8'hFF);
      for (int i = 0; i < 4; i++) send_request(OP_READ, 8'h00);
      send_request(OP_READ, 8'h00);
      req_valid <= 1'b0;
      drain();

      random_done = 0;
      while (random_done < 400) begin
         w    = pick_size();
         h    = pick_size();
         if (sb.clamp_to(w, MAX_WIDTH) * sb.clamp_to(h, MAX_HEIGHT) > 256)
            h = 8'($urandom_range(1, 2));
         ch   = 8'($urandom_range(0, 255));
         mode = 8'($urandom_range(0, 255));
         frame = sb.clamp_to(w, MAX_WIDTH) * sb.clamp_to(h, MAX_HEIGHT)
                 * sb.clamp_to(ch[2:0], MAX_CHANNELS);
         if ($urandom_range(0, 3) == 0)
            n_items = $urandom_range(1, 2 * frame);
         else
            n_items = 2 * frame + $urandom_range(0, 10);
         if (n_items > 250) n_items = 250;
         configure(w, h, ch, mode);
         run_phase(n_items, $urandom_range(0, 3) != 0, 1'b0);
         random_done += n_items;
         drain();
      end

      // widest row: receiver holds off long enough to back up the input
      configure(8'd255, 8'd1, 8'd1, FLIP_BOTH);
      run_phase(262, 1'b1, 1'b1);
      drain();
      configure(8'd1, 8'd200, 8'd1, FLIP_VERT);
      run_phase(262, 1'b1, 1'b0);
      drain();
      configure(8'd128, 8'd1, 8'd1, 8'd3);
      run_phase(262, 1'b0, 1'b0);

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("[image_flip_engine_unit] OK");
      else
         $display("[image_flip_engine_unit] ERROR");
      $finish;
   end

endmodule
